// ----- design/assert_macros.svh -----
// Assertion macros for the curve point smoothing block.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define CPMA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpma assertion failed");
// Next-cycle implication, disabled while reset is high.
`define CPMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpma assertion failed");
`else
`define CPMA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CPMA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/cpma_pkg.sv -----
// Types and fixed constants of the curve point moving average block.
// No dependencies; imported by curve_point_moving_average and tb_top.
package cpma_pkg;

  localparam int COORD_W    = 32;
  localparam int HEAD_W     = 16;
  localparam int IDX_W      = 12;
  localparam int CNT_W      = 13;
  localparam int WIN_REG_W  = 7;
  localparam int CFG_W      = 13;
  localparam int IN_W       = 2 * COORD_W + HEAD_W;           // 80
  localparam int OUT_W      = 96;                             // 92 used, byte padded
  localparam int OUT_PAD_W  = OUT_W - (2 * COORD_W + HEAD_W + IDX_W);
  localparam int MAX_POINTS = 4096;
  localparam int MIN_POINTS = 200;

  typedef enum logic [1:0] {
    REG_WINDOW = 2'd0,
    REG_COUNT  = 2'd1,
    REG_READY  = 2'd2,
    REG_NONE   = 2'd3
  } reg_index_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SUB  = 7'b0000010,
    ST_ADD  = 7'b0000100,
    ST_READ = 7'b0001000,
    ST_WAIT = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

endpackage

// ----- design/curve_point_moving_average.sv -----
// Centered moving average over a stream of curve points, with a bit-serial divider.
// Depends on cpma_pkg and assert_macros.svh.
// Timing: an interior point goes through SUB, ADD, READ, WAIT, DIV and EMIT, with the
//   restoring divider in DIV giving one quotient bit per cycle over the SUMW-bit sum
//   (SUMW = 32 + log2(MAX_WINDOW)); a pass-through point skips DIV; the last point flushes
//   the rest of the curve through READ, WAIT and EMIT. One request is in flight; the next
//   is taken in the cycle after the result is loaded, later while the output stalls;
//   a point with no result frees the input after SUB and ADD.
// Reset: synchronous, clears control, sums, point counter, count and ready; sets the
//   window to four; the history memory holds no valid data until written.
`include "assert_macros.svh"

module curve_point_moving_average
  import cpma_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // east_in[31:0], north_in[63:32], heading_in[79:64]
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // east_out[31:0], north_out[63:32],
                                            // heading_out[79:64], point_index[91:80], zero pad
  output logic              m_axis_tlast    // is_last
);

  // slot index into the history, effective window width, running sum width
  localparam int SW   = $clog2(MAX_WINDOW);
  localparam int WW   = $clog2(MAX_WINDOW + 1);
  localparam int AW   = WW + 1;
  localparam int SUMW = COORD_W + SW;
  localparam int DCW  = $clog2(SUMW + 1);
  localparam int CMPW = (WW > WIN_REG_W) ? WW : WIN_REG_W;
  localparam logic [SW-1:0] SLOT_LAST = SW'(MAX_WINDOW - 1);

  // configuration registers
  logic [WIN_REG_W-1:0] window_size;
  logic [CNT_W-1:0]     point_count;
  logic                 curve_ready;

  // control state
  state_t               state;
  logic [IDX_W-1:0]     p;          // points received in this curve
  logic [SW-1:0]        wr_slot;    // p modulo MAX_WINDOW
  logic [IDX_W-1:0]     cur_i;      // index of the result being built
  logic [SW-1:0]        cur_slot;   // cur_i modulo MAX_WINDOW
  logic                 last_q;     // current request is the last point of the curve
  logic                 interior;   // current result is an averaged point
  logic [DCW-1:0]       div_cnt;
  logic signed [SUMW-1:0] east_sum;
  logic signed [SUMW-1:0] north_sum;

  // datapath registers
  logic [COORD_W-1:0]   east_q;
  logic [COORD_W-1:0]   north_q;
  logic [HEAD_W-1:0]    head_q;
  logic [IN_W-1:0]      rd_q;
  logic [SUMW-1:0]      dvd_e;
  logic [SUMW-1:0]      dvd_n;
  logic [WW-1:0]        rem_e;
  logic [WW-1:0]        rem_n;
  logic                 neg_e;
  logic                 neg_n;

  // history memory: {heading, north, east} per slot
  logic [IN_W-1:0]      hist_mem [MAX_WINDOW];

  // Clamp the window to 2 .. MAX_WINDOW and the count to MAX_POINTS.
  logic [CMPW-1:0] w_sel;
  logic [WW-1:0]   w_eff;
  logic [WW-1:0]   half;
  logic [WW-1:0]   two_half;
  logic [CNT_W-1:0] n_eff;
  logic            active;

  always_comb begin
    w_sel = CMPW'(window_size);
    if (w_sel < CMPW'(2)) begin
      w_sel = CMPW'(2);
    end else if (w_sel > CMPW'(MAX_WINDOW)) begin
      w_sel = CMPW'(MAX_WINDOW);
    end
    w_eff    = WW'(w_sel);
    half     = w_eff >> 1;
    two_half = {half[WW-2:0], 1'b0};
    n_eff    = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;
    active   = curve_ready && (n_eff >= CNT_W'(MIN_POINTS));
  end

  // Slot arithmetic modulo MAX_WINDOW without a divider.
  logic [AW-1:0] old_diff;
  logic [AW-1:0] first_diff;
  logic [SW-1:0] old_slot;
  logic [SW-1:0] first_slot;
  logic [SW-1:0] wr_slot_inc;
  logic [SW-1:0] cur_slot_inc;

  always_comb begin
    old_diff   = AW'(wr_slot) - AW'(two_half);
    if (old_diff[AW-1]) begin
      old_diff = old_diff + AW'(MAX_WINDOW);
    end
    first_diff = AW'(wr_slot) + AW'(1) - AW'(half);
    if (first_diff[AW-1]) begin
      first_diff = first_diff + AW'(MAX_WINDOW);
    end
    old_slot     = SW'(old_diff);
    first_slot   = SW'(first_diff);
    wr_slot_inc  = (wr_slot == SLOT_LAST) ? '0 : wr_slot + SW'(1);
    cur_slot_inc = (cur_slot == SLOT_LAST) ? '0 : cur_slot + SW'(1);
  end

  // Point bookkeeping for the request in flight.
  logic [CNT_W-1:0] p_ext;
  logic [CNT_W-1:0] p_plus1;
  logic             pt_last;
  logic             has_result;
  logic             res_last;

  always_comb begin
    p_ext      = CNT_W'(p);
    p_plus1    = p_ext + CNT_W'(1);
    pt_last    = (p_plus1 == n_eff);
    has_result = (p_plus1 >= CNT_W'(half));
    res_last   = ((CNT_W'(cur_i) + CNT_W'(1)) == n_eff);
  end

  // Handshakes.
  logic in_acc;
  logic out_free;
  logic out_load;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = (state == ST_EMIT) && out_free;

  // Memory ports: read the outgoing slot at request time, the result slot in READ.
  logic          mem_we;
  logic          mem_re;
  logic [SW-1:0] rd_addr;

  assign mem_we  = (state == ST_ADD);
  assign mem_re  = (in_acc && active) || (state == ST_READ);
  assign rd_addr = (state == ST_IDLE) ? old_slot : cur_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wr_slot] <= {head_q, north_q, east_q};
    end
    if (mem_re) begin
      rd_q <= hist_mem[rd_addr];
    end
  end

  // Bit-serial restoring divide step, east and north side by side.
  logic [WW:0]   rem_sh_e;
  logic [WW:0]   rem_sh_n;
  logic          ge_e;
  logic          ge_n;
  logic [WW:0]   rem_sub_e;
  logic [WW:0]   rem_sub_n;

  always_comb begin
    rem_sh_e  = {rem_e, dvd_e[SUMW-1]};
    rem_sh_n  = {rem_n, dvd_n[SUMW-1]};
    ge_e      = (rem_sh_e >= {1'b0, w_eff});
    ge_n      = (rem_sh_n >= {1'b0, w_eff});
    rem_sub_e = rem_sh_e - {1'b0, w_eff};
    rem_sub_n = rem_sh_n - {1'b0, w_eff};
  end

  // Signed quotients (truncated toward zero) and sign-extended history values.
  logic [SUMW-1:0] quo_e;
  logic [SUMW-1:0] quo_n;
  logic [SUMW-1:0] rd_e_ext;
  logic [SUMW-1:0] rd_n_ext;
  logic [SUMW-1:0] in_e_ext;
  logic [SUMW-1:0] in_n_ext;

  always_comb begin
    quo_e    = neg_e ? -dvd_e : dvd_e;
    quo_n    = neg_n ? -dvd_n : dvd_n;
    rd_e_ext = {{(SUMW-COORD_W){rd_q[COORD_W-1]}}, rd_q[COORD_W-1:0]};
    rd_n_ext = {{(SUMW-COORD_W){rd_q[2*COORD_W-1]}}, rd_q[2*COORD_W-1:COORD_W]};
    in_e_ext = {{(SUMW-COORD_W){east_q[COORD_W-1]}}, east_q};
    in_n_ext = {{(SUMW-COORD_W){north_q[COORD_W-1]}}, north_q};
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_size   <= WIN_REG_W'(4);
      point_count   <= '0;
      curve_ready   <= 1'b0;
      p             <= '0;
      wr_slot       <= '0;
      cur_i         <= '0;
      cur_slot      <= '0;
      last_q        <= 1'b0;
      interior      <= 1'b0;
      div_cnt       <= '0;
      east_sum      <= '0;
      north_sum     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // raise valid on a load, drop it once the result is taken
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          // drop requests while the curve is unset or too short
          if (in_acc && active) begin
            state <= ST_SUB;
          end
        end
        ST_SUB: begin
          // retire the point that leaves the window
          if (p_ext >= CNT_W'(two_half)) begin
            east_sum  <= east_sum - rd_e_ext;
            north_sum <= north_sum - rd_n_ext;
          end
          state <= ST_ADD;
        end
        ST_ADD: begin
          east_sum  <= east_sum + in_e_ext;
          north_sum <= north_sum + in_n_ext;
          last_q    <= pt_last;
          cur_i     <= IDX_W'(p_plus1 - CNT_W'(half));
          cur_slot  <= first_slot;
          interior  <= (p_plus1 >= CNT_W'(two_half)) && !pt_last;
          if (has_result) begin
            state <= ST_READ;
          end else if (pt_last) begin
            p       <= '0;
            wr_slot <= '0;
            state   <= ST_IDLE;
          end else begin
            p       <= p + IDX_W'(1);
            wr_slot <= wr_slot_inc;
            state   <= ST_IDLE;
          end
        end
        ST_READ: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          div_cnt <= '0;
          state   <= interior ? ST_DIV : ST_EMIT;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(SUMW - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            interior      <= 1'b0;
            if (last_q && (cur_i != p)) begin
              // flush the tail: next point passes through
              cur_i    <= cur_i + IDX_W'(1);
              cur_slot <= cur_slot_inc;
              state    <= ST_READ;
            end else if (last_q) begin
              p         <= '0;
              wr_slot   <= '0;
              east_sum  <= '0;
              north_sum <= '0;
              state     <= ST_IDLE;
            end else begin
              p       <= p + IDX_W'(1);
              wr_slot <= wr_slot_inc;
              state   <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // any valid register write restarts the curve
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_WINDOW: window_size <= cfg_data[WIN_REG_W-1:0];
          REG_COUNT:  point_count <= cfg_data[CNT_W-1:0];
          REG_READY:  curve_ready <= cfg_data[0];
          default:    ;
        endcase
        if (reg_index_t'(cfg_index) != REG_NONE) begin
          p         <= '0;
          wr_slot   <= '0;
          east_sum  <= '0;
          north_sum <= '0;
        end
      end
    end
  end

  // Datapath: latch the request, run the divider, load the result register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      east_q  <= s_axis_tdata[COORD_W-1:0];
      north_q <= s_axis_tdata[2*COORD_W-1:COORD_W];
      head_q  <= s_axis_tdata[IN_W-1:2*COORD_W];
    end
    if (state == ST_WAIT) begin
      // hold magnitudes in the shift registers, keep the signs aside
      neg_e <= east_sum[SUMW-1];
      neg_n <= north_sum[SUMW-1];
      dvd_e <= east_sum[SUMW-1] ? SUMW'(-east_sum) : SUMW'(east_sum);
      dvd_n <= north_sum[SUMW-1] ? SUMW'(-north_sum) : SUMW'(north_sum);
      rem_e <= '0;
      rem_n <= '0;
    end else if (state == ST_DIV) begin
      // shift one dividend bit out into the remainder, one quotient bit in per cycle
      rem_e <= ge_e ? rem_sub_e[WW-1:0] : rem_sh_e[WW-1:0];
      rem_n <= ge_n ? rem_sub_n[WW-1:0] : rem_sh_n[WW-1:0];
      dvd_e <= {dvd_e[SUMW-2:0], ge_e};
      dvd_n <= {dvd_n[SUMW-2:0], ge_n};
    end
    if (out_load) begin
      m_axis_tdata <= {{OUT_PAD_W{1'b0}}, cur_i, rd_q[IN_W-1:2*COORD_W],
                       interior ? quo_n[COORD_W-1:0] : rd_q[2*COORD_W-1:COORD_W],
                       interior ? quo_e[COORD_W-1:0] : rd_q[COORD_W-1:0]};
      m_axis_tlast <= res_last;
    end
  end

  // The divider never runs past its last bit.
  `CPMA_ASSERT_IMPL(a_div_count, clk, rst, state == ST_DIV, div_cnt < DCW'(SUMW))
  // Emitting the final point of a curve always ends in a restarted, idle block.
  `CPMA_ASSERT_NEXT(a_last_restarts, clk, rst, out_load && res_last, (state == ST_IDLE) && (p == '0))
  // The point counter stays inside the configured curve.
  `CPMA_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, (p == '0) || (CNT_W'(p) < n_eff))

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for curve_point_moving_average: random and directed curve points
// go in, every smoothed point that comes out is checked against an in-bench predictor.
// Depends on cpma_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top
  import cpma_pkg::*;
;

  localparam int HIST_DEPTH    = 64;     // history depth of the block (MAX_WINDOW)
  localparam int SETTLE_CYCLES = 100;    // one interior point, with margin
  localparam int STALL_LIMIT   = 3000;   // cycles without any handshake before giving up

  typedef struct {
    logic [COORD_W-1:0] east;
    logic [COORD_W-1:0] north;
    logic [HEAD_W-1:0]  heading;
    logic [IDX_W-1:0]   index;
    logic               last;
  } smoothed_point_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = REG_NONE;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tlast;

  curve_point_moving_average dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor copy of the block's configuration and state.
  logic [WIN_REG_W-1:0] window_reg;
  logic [CNT_W-1:0]     count_reg;
  logic                 ready_reg;
  logic signed [COORD_W-1:0] east_hist  [HIST_DEPTH];
  logic signed [COORD_W-1:0] north_hist [HIST_DEPTH];
  logic [HEAD_W-1:0]         head_hist  [HIST_DEPTH];
  longint                    east_sum;
  longint                    north_sum;
  int unsigned               points_seen;

  smoothed_point_t pending_points[$];
  int              mismatches = 0;
  int              stall_cycles = 0;
  bit              tx_steady = 1'b0;   // sender never idles while set
  bit              rx_steady = 1'b0;   // receiver never stalls while set

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [HEAD_W-1:0] rand_heading();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return HEAD_W'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic restart_curve();
    points_seen = 0;
    east_sum    = 0;
    north_sum   = 0;
  endtask

  // Queue the expected output for curve point i.
  task automatic queue_point(input int unsigned i, input int unsigned n,
                             input int unsigned half, input int unsigned w);
    smoothed_point_t r;
    int unsigned     slot;
    longint          q_e;
    longint          q_n;
    slot = i % HIST_DEPTH;
    if (i >= half && i + half < n) begin
      // signed divide truncates toward zero
      q_e = east_sum / longint'(w);
      q_n = north_sum / longint'(w);
    end else begin
      q_e = longint'(east_hist[slot]);
      q_n = longint'(north_hist[slot]);
    end
    r.east    = q_e[COORD_W-1:0];
    r.north   = q_n[COORD_W-1:0];
    r.heading = head_hist[slot];
    r.index   = i[IDX_W-1:0];
    r.last    = (i + 1 == n);
    pending_points.push_back(r);
  endtask

  // Advance the predictor by one accepted curve point.
  task automatic predict_point(input logic signed [COORD_W-1:0] e,
                               input logic signed [COORD_W-1:0] n_in,
                               input logic [HEAD_W-1:0] h);
    int unsigned w, half, cnt, p, slot, old, first, i;
    w = window_reg;
    if (w < 2) w = 2;
    if (w > HIST_DEPTH) w = HIST_DEPTH;
    half = w / 2;
    cnt = count_reg;
    if (cnt > MAX_POINTS) cnt = MAX_POINTS;
    if (!ready_reg || cnt < MIN_POINTS) return;
    p = points_seen;
    if (p >= cnt) begin
      restart_curve();
      p = 0;
    end
    slot = p % HIST_DEPTH;
    if (p >= 2 * half) begin
      old = (p - 2 * half) % HIST_DEPTH;
      east_sum  -= longint'(east_hist[old]);
      north_sum -= longint'(north_hist[old]);
    end
    east_hist[slot]  = e;
    north_hist[slot] = n_in;
    head_hist[slot]  = h;
    east_sum  += longint'(e);
    north_sum += longint'(n_in);
    first = 0;
    if (p + 1 >= half) begin
      first = p + 1 - half;
      queue_point(first, cnt, half, w);
      first++;
    end
    if (p + 1 == cnt) begin
      // last point flushes the tail
      for (i = first; i <= p; i++) queue_point(i, cnt, half, w);
      restart_curve();
    end else begin
      points_seen = p + 1;
    end
  endtask

  // Offer one point and hold it until the block takes it.
  task automatic send_point(input logic [COORD_W-1:0] e, input logic [COORD_W-1:0] n_in,
                            input logic [HEAD_W-1:0] h);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {h, n_in, e};
    do @(posedge clk); while (!s_axis_tready);
    predict_point(e, n_in, h);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_point(rand_coord(), rand_coord(), rand_heading());
  endtask

  task automatic stop_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    stop_stream();
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  // Drain and let a point that produces no output finish inside the block.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; the block must be idle.
  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WINDOW: window_reg = value[WIN_REG_W-1:0];
      REG_COUNT:  count_reg  = value[CNT_W-1:0];
      REG_READY:  ready_reg  = value[0];
      default:    return;   // unused index: no restart
    endcase
    restart_curve();
  endtask

  // Check each result leaving the block against the oldest expectation.
  always @(posedge clk) begin
    smoothed_point_t exp_pt;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_points.size() == 0) begin
        flag_mismatch($sformatf("unexpected result index %0d", m_axis_tdata[91:80]));
      end else begin
        exp_pt = pending_points.pop_front();
        if (m_axis_tdata[31:0] !== exp_pt.east)
          flag_mismatch($sformatf("point %0d east %h, want %h", exp_pt.index,
                                  m_axis_tdata[31:0], exp_pt.east));
        if (m_axis_tdata[63:32] !== exp_pt.north)
          flag_mismatch($sformatf("point %0d north %h, want %h", exp_pt.index,
                                  m_axis_tdata[63:32], exp_pt.north));
        if (m_axis_tdata[79:64] !== exp_pt.heading)
          flag_mismatch($sformatf("point %0d heading %h, want %h", exp_pt.index,
                                  m_axis_tdata[79:64], exp_pt.heading));
        if (m_axis_tdata[91:80] !== exp_pt.index)
          flag_mismatch($sformatf("index %0d, want %0d", m_axis_tdata[91:80], exp_pt.index));
        if (m_axis_tlast !== exp_pt.last)
          flag_mismatch($sformatf("point %0d last %b, want %b", exp_pt.index,
                                  m_axis_tlast, exp_pt.last));
        if (m_axis_tdata[OUT_W-1:92] !== '0)
          flag_mismatch($sformatf("point %0d pad bits %h", exp_pt.index,
                                  m_axis_tdata[OUT_W-1:92]));
      end
    end
  end

  // Receiver: bursts of ready broken by stalls of random length.
  initial begin
    int burst, gap;
    @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      burst = $urandom_range(1, 24);
      repeat (burst) @(posedge clk);
      gap = rx_steady ? 0 : pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Curve not set, empty count, count one below the minimum: everything is dropped.
  task automatic test_disabled_block();
    send_random(2);
    settle();
    write_reg(REG_READY, 13'd1);
    send_random(2);
    settle();
    write_reg(REG_COUNT, 13'(MIN_POINTS - 1));
    send_random(2);
    settle();
  endtask

  // Reset window of four, extreme coordinates; an unused index must not restart.
  task automatic test_default_window();
    write_reg(REG_COUNT, 13'(MIN_POINTS));
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 16'hA5A5);
    settle();
    write_reg(REG_NONE, CFG_W'($urandom));
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 16'h5A5A);
    send_point(32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
    send_point(32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
    settle();
  endtask

  // Window below the minimum clamps to two; then the widest window of 64, count clamped.
  task automatic test_window_limits();
    write_reg(REG_WINDOW, 13'd0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0001);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
    send_point(32'h8000_0000, 32'h8000_0000, 16'h7FFF);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFE);
    settle();
    write_reg(REG_WINDOW, 13'd1);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h1234);
    send_point(32'h0000_0001, 32'h8000_0000, 16'hFEDC);
    settle();
    write_reg(REG_WINDOW, 13'(HIST_DEPTH));
    write_reg(REG_COUNT, 13'h1FFF);
    send_random(6);
    settle();
  endtask

  // Whole curve at the widest window: interior sums, a full flush, then a new curve.
  task automatic test_full_curve_wide_window();
    write_reg(REG_WINDOW, 13'($urandom_range(HIST_DEPTH, 127)));
    write_reg(REG_COUNT, 13'(MIN_POINTS));
    write_reg(REG_READY, 13'd1);
    send_random(100);
    drain();   // hold the sender until every result is out
    send_random(MIN_POINTS - 100);
    send_random(3);
    settle();
  endtask

  // Odd window (divisor one more than the summed points), clamped count,
  // and a restart in the middle of the curve.
  task automatic test_partial_curve_odd_window();
    logic [CFG_W-1:0] win;
    win = 13'($urandom_range(1, 31) * 2 + 1);
    write_reg(REG_WINDOW, win);
    write_reg(REG_COUNT, 13'($urandom_range(MAX_POINTS + 1, 8191)));
    send_random(30);
    settle();
    write_reg(REG_WINDOW, win);
    send_random(30);
    settle();
  endtask

  // Narrowest window with both sides running flat out.
  task automatic test_narrow_window();
    write_reg(REG_WINDOW, 13'd2);
    write_reg(REG_COUNT, 13'(MAX_POINTS));
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_random(16);
    drain();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    settle();
  endtask

  // Points sent while the curve is cleared must vanish.
  task automatic test_noise();
    write_reg(REG_READY, 13'd0);
    send_random(8);
    settle();
  endtask

  initial begin
    window_reg = 7'd4;
    count_reg  = '0;
    ready_reg  = 1'b0;
    restart_curve();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled_block();
    test_default_window();
    test_window_limits();
    test_full_curve_wide_window();
    test_partial_curve_odd_window();
    test_narrow_window();
    test_noise();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
